### sv/lut3d_tetrahedral_interp_macros.svh
// Assertion macros for the 3D LUT interpolator.
// Included by the top level; no other dependencies.
`ifndef LUT3D_TETRAHEDRAL_INTERP_MACROS_SVH
`define LUT3D_TETRAHEDRAL_INTERP_MACROS_SVH
`ifndef SYNTHESIS
`define L3D_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define L3D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define L3D_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define L3D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### sv/l3d_pkg.sv
// Shared types and constants of the 3D LUT interpolator.
// No dependencies.
`default_nettype none
package l3d_pkg;
   localparam int VAL_W    = 20;
   localparam int CFG_W    = 6;
   localparam int SAT_MAX  = 524287;
   localparam int SAT_MIN  = -524288;
   localparam logic [CFG_W-1:0] GRID_RESET = 6'd33;

   typedef logic signed [VAL_W-1:0] val_type;

   typedef enum logic {
      ACT_LOAD  = 1'b0,
      ACT_PIXEL = 1'b1
   } action_type;

   // One table write request.
   typedef struct packed {
      logic    en;
      val_type red;
      val_type green;
      val_type blue;
   } wr_type;
endpackage
`default_nettype wire

### sv/lut3d_tetrahedral_interp.sv
// Top level of the 3D LUT tetrahedral interpolator.
// Uses l3d_pkg, l3d_coord, l3d_store, l3d_blend and the assertion macros.
`default_nettype none
`include "lut3d_tetrahedral_interp_macros.svh"

// Applies a 3D color table to a pixel stream, one word per clock while the
// output word is not stalled. Load words (action 0) write one grid entry;
// pixel words (action 1) return one interpolated pixel. The pipeline is five
// register stages: input scaling, corner sort and address, table read,
// multiply, and sum with rounding into the output register. The table is
// held in four copies so all four corners are read together. The whole
// pipeline holds while a result waits under stall. grid_size is held in a
// register feeding registered size constants; write it only while the block is idle.
module lut3d_tetrahedral_interp #(
   parameter int MAX_GRID  = 33,
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [l3d_pkg::CFG_W-1:0] csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_action,
   input  logic [15:0]             req_entry_index,
   input  l3d_pkg::val_type        req_entry_red,
   input  l3d_pkg::val_type        req_entry_green,
   input  l3d_pkg::val_type        req_entry_blue,
   input  l3d_pkg::val_type        req_in_red,
   input  l3d_pkg::val_type        req_in_green,
   input  l3d_pkg::val_type        req_in_blue,
   input  l3d_pkg::val_type        req_in_alpha,
   input  logic                    req_pixel_last,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output l3d_pkg::val_type        rsp_out_red,
   output l3d_pkg::val_type        rsp_out_green,
   output l3d_pkg::val_type        rsp_out_blue,
   output l3d_pkg::val_type        rsp_out_alpha,
   output logic                    rsp_out_last
);
   localparam int IW    = $clog2(MAX_GRID);
   localparam int SW    = $clog2(MAX_GRID + 1);
   localparam int DEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
   localparam int AW    = $clog2(DEPTH);
   localparam int WW    = FRAC_BITS + 1;
   localparam int MW    = IW + 2 * SW;
   localparam int GW    = (SW > l3d_pkg::CFG_W) ? SW : l3d_pkg::CFG_W;
   localparam int LW    = (AW + 1 > 17) ? AW + 1 : 17;
   localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;
   localparam int VW    = l3d_pkg::VAL_W;

   // Pipeline advance: everything holds while the output word is stalled.
   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // Configuration register and derived grid constants.
   logic [l3d_pkg::CFG_W-1:0] grid_ff;
   logic [SW-1:0]             size_ff, size_in, top_ff;
   logic [2*SW-1:0]           s2_ff;
   logic [GW-1:0]             grid_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff <= l3d_pkg::GRID_RESET;
      end else if (csr_wr_en) begin
         grid_ff <= csr_wr_data;
      end
   end

   always_comb begin
      grid_ext = GW'(grid_ff);
      if (grid_ext < GW'(2)) begin
         size_in = SW'(2);
      end else if (grid_ext > GW'(MAX_GRID)) begin
         size_in = SW'(MAX_GRID);
      end else begin
         size_in = SW'(grid_ext);
      end
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;
      top_ff  <= size_in - SW'(1);
      s2_ff   <= (2*SW)'(size_ff) * (2*SW)'(size_ff);
   end

   // Stage A: clamp and scale each channel.
   logic [IW-1:0]        lo_c [3], hi_c [3];
   logic [FRAC_BITS-1:0] d_c [3];
   l3d_pkg::val_type     chan [3];

   assign chan[0] = req_in_red;
   assign chan[1] = req_in_green;
   assign chan[2] = req_in_blue;

   for (genvar c = 0; c < 3; c++) begin : g_coord
      l3d_coord #(.FRAC_BITS(FRAC_BITS), .IW(IW), .SW(SW)) u_coord (
         .value (chan[c]),
         .top   (top_ff),
         .lo    (lo_c[c]),
         .hi    (hi_c[c]),
         .frac  (d_c[c])
      );
   end

   logic                 va_ff, acta_ff, last_a_ff;
   logic [IW-1:0]        lo_a_ff [3], hi_a_ff [3];
   logic [FRAC_BITS-1:0] d_a_ff [3];
   l3d_pkg::val_type     alpha_a_ff;
   logic [15:0]          eidx_a_ff;
   l3d_pkg::wr_type      ewr_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acta_ff    <= req_action;
         last_a_ff  <= req_pixel_last;
         alpha_a_ff <= req_in_alpha;
         eidx_a_ff  <= req_entry_index;
         ewr_a_ff   <= '{en: 1'b1, red: req_entry_red, green: req_entry_green,
                         blue: req_entry_blue};
         lo_a_ff    <= lo_c;
         hi_a_ff    <= hi_c;
         d_a_ff     <= d_c;
      end
   end

   // Stage B: order the fractions, pick the tetrahedron, form addresses.
   logic                 gr, gg, gb;
   logic [IW-1:0]        ar, ag, ab, br, bg, bb;
   logic [FRAC_BITS-1:0] mn, mx, x0, x1, x2, mid;
   logic [AW-1:0]        addr_in [4];
   logic [WW-1:0]        w_in [4];
   logic                 load_ok;

   function automatic logic [AW-1:0] flat(input logic [IW-1:0] r, input logic [IW-1:0] g,
                                          input logic [IW-1:0] b, input logic [2*SW-1:0] s2,
                                          input logic [SW-1:0] sz);
      logic [MW-1:0] acc;
      acc = MW'(r) * MW'(s2) + MW'(g) * MW'(sz) + MW'(b);
      return acc[AW-1:0];
   endfunction

   always_comb begin
      gr = d_a_ff[0] > d_a_ff[1];
      gg = d_a_ff[1] > d_a_ff[2];
      gb = d_a_ff[2] > d_a_ff[0];
      ar = (!gb && gr) ? hi_a_ff[0] : lo_a_ff[0];
      ag = (!gr && gg) ? hi_a_ff[1] : lo_a_ff[1];
      ab = (!gg && gb) ? hi_a_ff[2] : lo_a_ff[2];
      br = (!gr && gb) ? lo_a_ff[0] : hi_a_ff[0];
      bg = (!gg && gr) ? lo_a_ff[1] : hi_a_ff[1];
      bb = (!gb && gg) ? lo_a_ff[2] : hi_a_ff[2];
      addr_in[0] = flat(lo_a_ff[0], lo_a_ff[1], lo_a_ff[2], s2_ff, size_ff);
      addr_in[1] = flat(ar, ag, ab, s2_ff, size_ff);
      addr_in[2] = flat(br, bg, bb, s2_ff, size_ff);
      addr_in[3] = flat(hi_a_ff[0], hi_a_ff[1], hi_a_ff[2], s2_ff, size_ff);
      mn  = (d_a_ff[0] < d_a_ff[1]) ? d_a_ff[0] : d_a_ff[1];
      mx  = (d_a_ff[0] < d_a_ff[1]) ? d_a_ff[1] : d_a_ff[0];
      x2  = (mn < d_a_ff[2]) ? mn : d_a_ff[2];
      mid = (mn < d_a_ff[2]) ? d_a_ff[2] : mn;
      x0  = (mx > d_a_ff[2]) ? mx : d_a_ff[2];
      x1  = (mx < mid) ? mx : mid;
      w_in[0] = ONE - WW'(x0);
      w_in[1] = WW'(x0) - WW'(x1);
      w_in[2] = WW'(x1) - WW'(x2);
      w_in[3] = WW'(x2);
      load_ok = LW'(eidx_a_ff) < LW'(DEPTH);
   end

   logic             vb_ff, actb_ff, last_b_ff;
   logic [AW-1:0]    addr_b_ff [4];
   logic [WW-1:0]    w_b_ff [4];
   l3d_pkg::val_type alpha_b_ff;
   logic [AW-1:0]    waddr_b_ff;
   l3d_pkg::wr_type  wr_b_ff, wr_req;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         actb_ff    <= acta_ff;
         last_b_ff  <= last_a_ff;
         alpha_b_ff <= alpha_a_ff;
         addr_b_ff  <= addr_in;
         w_b_ff     <= w_in;
         waddr_b_ff <= AW'(eidx_a_ff);
         wr_b_ff    <= '{en: load_ok, red: ewr_a_ff.red, green: ewr_a_ff.green,
                         blue: ewr_a_ff.blue};
      end
   end

   // A load word with an in-range index writes the table here; pixels read in the same stage.
   always_comb begin
      wr_req    = wr_b_ff;
      wr_req.en = vb_ff && (actb_ff == l3d_pkg::ACT_LOAD) && wr_b_ff.en;
   end

   // Stage C: table read.
   logic [3*VW-1:0]  rd_data [4];
   logic             vc_ff, last_c_ff;
   logic [WW-1:0]    w_c_ff [4];
   l3d_pkg::val_type alpha_c_ff;

   l3d_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock   (clock),
      .en      (en),
      .wr      (wr_req),
      .wr_addr (waddr_b_ff),
      .rd_addr (addr_b_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (en) begin
         vc_ff <= vb_ff && (actb_ff == l3d_pkg::ACT_PIXEL);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         last_c_ff  <= last_b_ff;
         alpha_c_ff <= alpha_b_ff;
         w_c_ff     <= w_b_ff;
      end
   end

   // Stages D and E: per channel blend, output register inside.
   l3d_pkg::val_type corner [3][4];
   l3d_pkg::val_type blend_q [3];

   for (genvar c = 0; c < 3; c++) begin : g_blend
      for (genvar k = 0; k < 4; k++) begin : g_corner
         assign corner[c][k] = rd_data[k][(2 - c) * VW +: VW];
      end
      l3d_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
         .clock     (clock),
         .en        (en),
         .corner    (corner[c]),
         .weight    (w_c_ff),
         .result_ff (blend_q[c])
      );
   end

   logic             vd_ff, last_d_ff, rsp_valid_ff, rsp_last_ff;
   l3d_pkg::val_type alpha_d_ff, rsp_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vd_ff        <= vc_ff;
         rsp_valid_ff <= vd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         last_d_ff    <= last_c_ff;
         alpha_d_ff   <= alpha_c_ff;
         rsp_last_ff  <= last_d_ff;
         rsp_alpha_ff <= alpha_d_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = blend_q[0];
   assign rsp_out_green = blend_q[1];
   assign rsp_out_blue  = blend_q[2];
   assign rsp_out_alpha = rsp_alpha_ff;
   assign rsp_out_last  = rsp_last_ff;

   // A held output word blocks the input side.
   `L3D_ASSERT_SAME(a_hold_blocks_input, clock, reset, rsp_valid && rsp_stall, req_stall, "input accepted while output held")
   // A load word never turns into a result.
   `L3D_ASSERT_NEXT(a_load_no_result, clock, reset, vb_ff && (actb_ff == l3d_pkg::ACT_LOAD) && en, !vc_ff, "load word entered read stage as pixel")
   // A pixel in the multiply stage reaches the output on the next advance.
   `L3D_ASSERT_NEXT(a_pixel_reaches_out, clock, reset, vd_ff && en, rsp_valid, "pixel lost before output")
endmodule
`default_nettype wire

### sv/l3d_coord.sv
// Clamps one color channel, scales it by the grid top index and splits it.
// Uses l3d_pkg.
`default_nettype none
module l3d_coord #(
   parameter int FRAC_BITS = 16,
   parameter int IW        = 6,
   parameter int SW        = 6
) (
   input  l3d_pkg::val_type       value,
   input  logic [SW-1:0]          top,
   output logic [IW-1:0]          lo,
   output logic [IW-1:0]          hi,
   output logic [FRAC_BITS-1:0]   frac
);
   localparam int XW = FRAC_BITS + 1;
   localparam int CW = (FRAC_BITS + 2 > l3d_pkg::VAL_W + 1) ? FRAC_BITS + 2
                                                           : l3d_pkg::VAL_W + 1;
   localparam logic signed [CW-1:0] ONE = CW'(1) << FRAC_BITS;

   logic signed [CW-1:0] ext;
   logic [XW-1:0]        x;
   logic [XW+SW-1:0]     scaled;

   // Clamp to [0, 1.0], then scale to grid coordinates.
   always_comb begin
      ext = CW'(value);
      if (ext < 0) begin
         x = '0;
      end else if (ext > ONE) begin
         x = ONE[XW-1:0];
      end else begin
         x = ext[XW-1:0];
      end
      scaled = (XW+SW)'(x) * (XW+SW)'(top);
      lo     = scaled[FRAC_BITS +: IW];
      frac   = scaled[FRAC_BITS-1:0];
      if (SW'(lo) == top) begin
         hi = IW'(top);
      end else begin
         hi = lo + IW'(1);
      end
   end
endmodule
`default_nettype wire

### sv/l3d_store.sv
// Table store: four copies of the grid, each with one write and one read port.
// Uses l3d_pkg.
`default_nettype none
module l3d_store #(
   parameter int DEPTH = 35937,
   parameter int AW    = 16
) (
   input  logic              clock,
   input  logic              en,
   input  l3d_pkg::wr_type   wr,
   input  logic [AW-1:0]     wr_addr,
   input  logic [AW-1:0]     rd_addr [4],
   output logic [3*l3d_pkg::VAL_W-1:0] rd_data [4]
);
   localparam int DW = 3 * l3d_pkg::VAL_W;

   // Every copy takes every write, so each corner has its own read port.
   for (genvar k = 0; k < 4; k++) begin : g_bank
      logic [DW-1:0] mem [DEPTH];
      always_ff @(posedge clock) begin
         if (en) begin
            if (wr.en) begin
               mem[wr_addr] <= {wr.red, wr.green, wr.blue};
            end
            rd_data[k] <= mem[rd_addr[k]];
         end
      end
   end
endmodule
`default_nettype wire

### sv/l3d_blend.sv
// Weighted sum of four corner values for one channel, rounded and saturated.
// Two register stages; uses l3d_pkg.
`default_nettype none
module l3d_blend #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   en,
   input  l3d_pkg::val_type       corner [4],
   input  logic [FRAC_BITS:0]     weight [4],
   output l3d_pkg::val_type       result_ff
);
   localparam int WW   = FRAC_BITS + 1;
   localparam int PW   = WW + 1 + l3d_pkg::VAL_W;
   localparam int SUMW = PW + 2;
   localparam int QW   = SUMW - FRAC_BITS;
   localparam logic signed [SUMW-1:0] HALF = SUMW'(1) << (FRAC_BITS - 1);
   localparam logic signed [QW-1:0]   QMAX = QW'(l3d_pkg::SAT_MAX);
   localparam logic signed [QW-1:0]   QMIN = QW'(l3d_pkg::SAT_MIN);

   logic signed [PW-1:0]   prod_ff [4];
   logic signed [SUMW-1:0] sum;
   logic signed [SUMW-1:0] rnd;
   logic signed [QW-1:0]   q;
   l3d_pkg::val_type       result_in;

   // Stage one: the four products.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            prod_ff[k] <= $signed({1'b0, weight[k]}) * corner[k];
         end
      end
   end

   // Stage two: sum, round half up, saturate.
   always_comb begin
      sum = SUMW'(prod_ff[0]) + SUMW'(prod_ff[1]) + SUMW'(prod_ff[2]) + SUMW'(prod_ff[3]);
      rnd = sum + HALF;
      q   = QW'(rnd >>> FRAC_BITS);
      if (q > QMAX) begin
         result_in = l3d_pkg::VAL_W'(l3d_pkg::SAT_MAX);
      end else if (q < QMIN) begin
         result_in = l3d_pkg::VAL_W'(l3d_pkg::SAT_MIN);
      end else begin
         result_in = q[l3d_pkg::VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
      end
   end
endmodule
`default_nettype wire
